// ----- hdl/lfpd_pkg.sv -----
// shared types, widths, codes and reset values for the line follower pid drive
// no dependencies; compile first
package lfpd_pkg;

    // block constants
    localparam int SAMPLE_BITS = 10;
    localparam int DRIVE_MAX   = 1023;
    localparam int SUM_BITS    = 24;

    // fixed field widths
    localparam int GAIN_BITS  = 8;
    localparam int BASE_BITS  = 10;
    localparam int CODE_BITS  = 3;
    localparam int DIR_BITS   = 2;
    localparam int ERR_BITS   = 3;
    localparam int DIFF_BITS  = 4;
    localparam int DRIVE_BITS = $clog2(DRIVE_MAX + 1);

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = (SAMPLE_BITS > BASE_BITS) ? SAMPLE_BITS : BASE_BITS;

    // shared multiplier: zero-extended gain times signed operand
    localparam int MUL_A_BITS = GAIN_BITS + 1;
    localparam int MUL_B_BITS = SUM_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    // derivative term magnitude is at most gain_max * 6
    localparam int DIV_BITS     = $clog2(((1 << GAIN_BITS) - 1) * 6 + 1);
    localparam int Y_BITS       = DIV_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int X_BITS       = PROD_BITS + 1;
    localparam int Q_BITS       = X_BITS + 1;
    localparam int WHEEL_BITS   = Q_BITS + 1;

    // register reset values
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_PROP  = GAIN_BITS'(65);
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_INTEG = GAIN_BITS'(0);
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_DERIV = GAIN_BITS'(10);
    localparam logic [GAIN_BITS-1:0]   RST_STEP_TIME  = GAIN_BITS'(3);
    localparam logic [BASE_BITS-1:0]   RST_BASE_SPEED = BASE_BITS'(75);
    localparam logic [SAMPLE_BITS-1:0] RST_LEFT_THR   = SAMPLE_BITS'(265);
    localparam logic [SAMPLE_BITS-1:0] RST_MID_THR    = SAMPLE_BITS'(220);
    localparam logic [SAMPLE_BITS-1:0] RST_RIGHT_THR  = SAMPLE_BITS'(261);

    // sensor codes, bit2 left, bit1 middle, bit0 right
    localparam logic [CODE_BITS-1:0] CODE_LOST      = 3'b000;
    localparam logic [CODE_BITS-1:0] CODE_RIGHT     = 3'b001;
    localparam logic [CODE_BITS-1:0] CODE_CENTER    = 3'b010;
    localparam logic [CODE_BITS-1:0] CODE_RIGHT_MID = 3'b011;
    localparam logic [CODE_BITS-1:0] CODE_LEFT      = 3'b100;
    localparam logic [CODE_BITS-1:0] CODE_LEFT_MID  = 3'b110;

    // tracking errors
    localparam logic signed [ERR_BITS-1:0] ERR_NONE       = 3'sd0;
    localparam logic signed [ERR_BITS-1:0] ERR_LEFT       = -3'sd1;
    localparam logic signed [ERR_BITS-1:0] ERR_RIGHT      = 3'sd1;
    localparam logic signed [ERR_BITS-1:0] ERR_LEFT_LOST  = -3'sd3;
    localparam logic signed [ERR_BITS-1:0] ERR_RIGHT_LOST = 3'sd3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GAIN_PROP,
        CFG_GAIN_INTEG,
        CFG_GAIN_DERIV,
        CFG_STEP_TIME,
        CFG_BASE_SPEED,
        CFG_LEFT_THR,
        CFG_MID_THR,
        CFG_RIGHT_THR
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_PROP,
        ST_INTEG,
        ST_DERIV,
        ST_DSTART,
        ST_DIV,
        ST_ADJ,
        ST_DRIVE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_BITS-1:0]  dividend;
        logic [GAIN_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_BITS-1:0]  quot;
        logic [GAIN_BITS-1:0] rem;
    } div_rsp_t;

endpackage

// ----- hdl/lfpd_ifs.sv -----
// valid/ready channel interfaces for sensor samples and drive results
// depends on lfpd_pkg
interface lfpd_sense_if
    import lfpd_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] mid_sample;
    logic [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output mid_sample,
                    output right_sample, input ready);
    modport sink   (input valid, input left_sample, input mid_sample,
                    input right_sample, output ready);
endinterface

interface lfpd_drive_if
    import lfpd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [DIR_BITS-1:0]   wheel_direction;
    logic [DRIVE_BITS-1:0] left_drive;
    logic [DRIVE_BITS-1:0] right_drive;
    logic [CODE_BITS-1:0]  black_bits;

    modport source (output valid, output wheel_direction, output left_drive,
                    output right_drive, output black_bits, input ready);
    modport sink   (input valid, input wheel_direction, input left_drive,
                    input right_drive, input black_bits, output ready);
endinterface

// ----- hdl/lfpd_div.sv -----
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on lfpd_pkg
module lfpd_div
    import lfpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0]     quo_reg, quo_next;
    logic [GAIN_BITS-1:0]    rem_reg, rem_next;
    logic [GAIN_BITS-1:0]    dvs_reg, dvs_next;
    logic [GAIN_BITS:0]      trial;
    logic [GAIN_BITS:0]      diff;
    logic                    fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_BITS-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIV_BITS - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out at the top, quotient bits shift in below
            quo_next = {quo_reg[DIV_BITS-2:0], fits};
            rem_next = fits ? diff[GAIN_BITS-1:0] : trial[GAIN_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> (busy_reg && !done_reg))
        else $error("divider did not start iterating");

endmodule

// ----- hdl/line_follow_pid_drive.sv -----
// top level of the three-sensor pid line follower drive
// depends on lfpd_pkg, lfpd_ifs (channel interfaces) and lfpd_div
//
// usage:
//   sense  - sink channel, one beat carries left, middle and right samples
//   drive  - source channel, one beat carries wheel direction, both wheel
//            magnitudes and the black bits for the indicator lamps
//   cfg_*  - write-only register port (gains, step time, base speed and the
//            three thresholds); write only while the block is idle
// timing:
//   one sensor beat yields one drive beat; sense.ready comes back in the same
//   cycle the result is loaded, so one item is finished before the next sense
//   beat is taken. the item time is set by the shared
//   multiplier being used four times in a row and by the 11-step divide by
//   the step time in lfpd_div
//   the drive beat sits in an output register, so the next sense beat is taken
//   while it waits; if the receiver still stalls when the next result is due,
//   the sequencer holds in its final step until the register frees
// reset:
//   registers return to their default gains and thresholds, the line memory
//   reads centered, prior error and error sum clear, no drive beat pending
module line_follow_pid_drive
    import lfpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    lfpd_sense_if.sink                sense,
    lfpd_drive_if.source              drive,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // configuration registers
    logic [GAIN_BITS-1:0]   kp_reg;
    logic [GAIN_BITS-1:0]   ki_reg;
    logic [GAIN_BITS-1:0]   kd_reg;
    logic [GAIN_BITS-1:0]   step_reg;
    logic [BASE_BITS-1:0]   base_reg;
    logic [SAMPLE_BITS-1:0] left_thr_reg;
    logic [SAMPLE_BITS-1:0] mid_thr_reg;
    logic [SAMPLE_BITS-1:0] right_thr_reg;

    // controller state kept across items
    state_t                      state_reg, state_next;
    logic [CODE_BITS-1:0]        last_code_reg, last_code_next;
    logic signed [ERR_BITS-1:0]  prev_reg, prev_next;
    logic signed [SUM_BITS-1:0]  sum_reg, sum_next;

    // per-item working registers
    logic [CODE_BITS-1:0]        code_reg, code_next;
    logic signed [ERR_BITS-1:0]  e_reg, e_next;
    logic signed [X_BITS-1:0]    x_reg, x_next;
    logic signed [Y_BITS-1:0]    y_reg, y_next;
    logic signed [Q_BITS-1:0]    q_reg, q_next;
    logic                        rem_nz_reg, rem_nz_next;
    logic signed [Q_BITS-1:0]    pid_reg, pid_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [DIR_BITS-1:0]   dir_reg, dir_next;
    logic [DRIVE_BITS-1:0] left_reg, left_next;
    logic [DRIVE_BITS-1:0] right_reg, right_next;
    logic [CODE_BITS-1:0]  bits_reg, bits_next;

    // combinational helpers
    logic [GAIN_BITS-1:0]          dt_eff;
    logic [CODE_BITS-1:0]          code;
    logic signed [ERR_BITS-1:0]    e_new;
    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [SUM_BITS:0]      sum_wide;
    logic [Y_BITS-1:0]             y_mag;
    logic [Q_BITS-1:0]             quot_ext;
    logic signed [Q_BITS-1:0]      qy;
    logic                          q_pos;
    logic                          q_neg;
    logic signed [WHEEL_BITS-1:0]  left_w;
    logic signed [WHEEL_BITS-1:0]  right_w;
    logic [WHEEL_BITS-1:0]         left_mag;
    logic [WHEEL_BITS-1:0]         right_mag;
    logic                          accept;
    div_req_t                      div_req;
    div_rsp_t                      div_rsp;

    // a zero step time behaves as one
    assign dt_eff = (step_reg == '0) ? GAIN_BITS'(1) : step_reg;

    assign sense.ready = (state_reg == ST_IDLE);
    assign accept      = sense.valid && sense.ready;

    // black when below threshold
    assign code = {(sense.left_sample < left_thr_reg),
                   (sense.mid_sample < mid_thr_reg),
                   (sense.right_sample < right_thr_reg)};

    // code to tracking error; a lost line falls back on the side last seen
    always_comb
    begin
        case (code)
            CODE_CENTER:               e_new = ERR_NONE;
            CODE_LEFT, CODE_LEFT_MID:   e_new = ERR_LEFT;
            CODE_RIGHT, CODE_RIGHT_MID: e_new = ERR_RIGHT;
            CODE_LOST:
            begin
                if (last_code_reg inside {CODE_LEFT, CODE_LEFT_MID})
                    e_new = ERR_LEFT_LOST;
                else if (last_code_reg inside {CODE_RIGHT, CODE_RIGHT_MID})
                    e_new = ERR_RIGHT_LOST;
                else
                    e_new = ERR_NONE;
            end
            default:                   e_new = ERR_NONE;
        endcase
    end

    assign diff = DIFF_BITS'(e_reg) - DIFF_BITS'(prev_reg);

    // shared multiplier, operands picked by the sequencer step
    always_comb
    begin
        case (state_reg)
            ST_SUM:
            begin
                mul_a = $signed({1'b0, dt_eff});
                mul_b = MUL_B_BITS'(e_reg);
            end
            ST_PROP:
            begin
                mul_a = $signed({1'b0, kp_reg});
                mul_b = MUL_B_BITS'(e_reg);
            end
            ST_INTEG:
            begin
                mul_a = $signed({1'b0, ki_reg});
                mul_b = sum_reg;
            end
            ST_DERIV:
            begin
                mul_a = $signed({1'b0, kd_reg});
                mul_b = MUL_B_BITS'(diff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // saturating accumulate of e*dt
    assign sum_wide = (SUM_BITS + 1)'(sum_reg) + $signed(prod[SUM_BITS:0]);

    // derivative term magnitude goes to the divider, its sign stays here
    assign y_mag    = y_reg[Y_BITS-1] ? (Y_BITS'(0) - y_reg) : y_reg;
    assign quot_ext = Q_BITS'(div_rsp.quot);
    assign qy       = y_reg[Y_BITS-1] ? -$signed(quot_ext) : $signed(quot_ext);

    assign div_req.start    = (state_reg == ST_DSTART);
    assign div_req.dividend = y_mag[DIV_BITS-1:0];
    assign div_req.divisor  = dt_eff;

    // num = dt*(x + qy) + ry; truncation only moves the quotient by one when
    // the remainder sign opposes the sign of x + qy
    assign q_pos = !q_reg[Q_BITS-1] && (q_reg != '0);
    assign q_neg = q_reg[Q_BITS-1];

    // wheel values and their clamped magnitudes
    assign left_w    = WHEEL_BITS'($signed({1'b0, base_reg})) + WHEEL_BITS'(pid_reg);
    assign right_w   = WHEEL_BITS'($signed({1'b0, base_reg})) - WHEEL_BITS'(pid_reg);
    assign left_mag  = left_w[WHEEL_BITS-1] ? (WHEEL_BITS'(0) - left_w) : left_w;
    assign right_mag = right_w[WHEEL_BITS-1] ? (WHEEL_BITS'(0) - right_w) : right_w;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        last_code_next = last_code_reg;
        prev_next      = prev_reg;
        sum_next       = sum_reg;
        code_next      = code_reg;
        e_next         = e_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        q_next         = q_reg;
        rem_nz_next    = rem_nz_reg;
        pid_next       = pid_reg;
        out_valid_next = out_valid_reg && !drive.ready;
        dir_next       = dir_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        bits_next      = bits_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    code_next      = code;
                    e_next         = e_new;
                    last_code_next = code;
                    // centered line restarts the integral
                    if (code == CODE_CENTER)
                        sum_next = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
                    sum_next = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
                                                  : {1'b0, {(SUM_BITS - 1){1'b1}}};
                else
                    sum_next = sum_wide[SUM_BITS-1:0];
                state_next = ST_PROP;
            end
            ST_PROP:
            begin
                x_next     = X_BITS'(prod);
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                x_next     = x_reg + X_BITS'(prod);
                state_next = ST_DERIV;
            end
            ST_DERIV:
            begin
                y_next     = $signed(prod[Y_BITS-1:0]);
                prev_next  = e_reg;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    q_next      = Q_BITS'(x_reg) + qy;
                    rem_nz_next = (div_rsp.rem != '0);
                    state_next  = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                if (q_pos && rem_nz_reg && y_reg[Y_BITS-1])
                    pid_next = q_reg - Q_BITS'(1);
                else if (q_neg && rem_nz_reg && !y_reg[Y_BITS-1])
                    pid_next = q_reg + Q_BITS'(1);
                else
                    pid_next = q_reg;
                state_next = ST_DRIVE;
            end
            ST_DRIVE:
            begin
                // wait here while an earlier beat is still unclaimed
                if (!out_valid_reg || drive.ready)
                begin
                    out_valid_next = 1'b1;
                    dir_next       = {right_w[WHEEL_BITS-1], left_w[WHEEL_BITS-1]};
                    left_next      = (left_mag > WHEEL_BITS'(DRIVE_MAX))
                                     ? DRIVE_BITS'(DRIVE_MAX) : left_mag[DRIVE_BITS-1:0];
                    right_next     = (right_mag > WHEEL_BITS'(DRIVE_MAX))
                                     ? DRIVE_BITS'(DRIVE_MAX) : right_mag[DRIVE_BITS-1:0];
                    bits_next      = code_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_code_reg <= CODE_CENTER;
            prev_reg      <= ERR_NONE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_code_reg <= last_code_next;
            prev_reg      <= prev_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and output payload
    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        e_reg      <= e_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        q_reg      <= q_next;
        rem_nz_reg <= rem_nz_next;
        pid_reg    <= pid_next;
        dir_reg    <= dir_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        bits_reg   <= bits_next;
    end

    // register writes, upper data bits dropped per register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= RST_GAIN_PROP;
            ki_reg        <= RST_GAIN_INTEG;
            kd_reg        <= RST_GAIN_DERIV;
            step_reg      <= RST_STEP_TIME;
            base_reg      <= RST_BASE_SPEED;
            left_thr_reg  <= RST_LEFT_THR;
            mid_thr_reg   <= RST_MID_THR;
            right_thr_reg <= RST_RIGHT_THR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_PROP:  kp_reg        <= cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_INTEG: ki_reg        <= cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_DERIV: kd_reg        <= cfg_data[GAIN_BITS-1:0];
                CFG_STEP_TIME:  step_reg      <= cfg_data[GAIN_BITS-1:0];
                CFG_BASE_SPEED: base_reg      <= cfg_data[BASE_BITS-1:0];
                CFG_LEFT_THR:   left_thr_reg  <= cfg_data[SAMPLE_BITS-1:0];
                CFG_MID_THR:    mid_thr_reg   <= cfg_data[SAMPLE_BITS-1:0];
                CFG_RIGHT_THR:  right_thr_reg <= cfg_data[SAMPLE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // divide of the derivative term by the step time
    lfpd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign drive.valid           = out_valid_reg;
    assign drive.wheel_direction = dir_reg;
    assign drive.left_drive      = left_reg;
    assign drive.right_drive     = right_reg;
    assign drive.black_bits      = bits_reg;

    a_result_from_drive: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(drive.valid) |-> ($past(state_reg) == ST_DRIVE))
        else $error("drive beat raised outside the final step");

    a_center_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (code == CODE_CENTER)) |=> (sum_reg == '0))
        else $error("centered line did not clear error sum");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait step");

endmodule

// ----- sim/lfpd_drive_checker.sv -----
// beat checker for the line follower pid drive: predicts one drive beat per sensor beat
// and compares it field by field; depends on lfpd_pkg and the lfpd_ifs channel interfaces
module lfpd_drive_checker
    import lfpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    lfpd_sense_if                     sense,
    lfpd_drive_if                     drive,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int unsigned               mismatches,
    output int unsigned               owed
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [DIR_BITS-1:0] DIR_LEFT_BACK  = 2'b01;
    localparam logic [DIR_BITS-1:0] DIR_RIGHT_BACK = 2'b10;
    localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct packed {
        logic [DIR_BITS-1:0]   dir;
        logic [DRIVE_BITS-1:0] left_mag;
        logic [DRIVE_BITS-1:0] right_mag;
        logic [CODE_BITS-1:0]  black;
    } wheel_cmd_t;

    // register copies
    logic [GAIN_BITS-1:0]   kp;
    logic [GAIN_BITS-1:0]   ki;
    logic [GAIN_BITS-1:0]   kd;
    logic [GAIN_BITS-1:0]   period;
    logic [BASE_BITS-1:0]   base;
    logic [SAMPLE_BITS-1:0] thr_left;
    logic [SAMPLE_BITS-1:0] thr_mid;
    logic [SAMPLE_BITS-1:0] thr_right;

    // tracking state
    logic [CODE_BITS-1:0] last_seen;
    longint               prior_err;
    longint               err_sum;

    wheel_cmd_t  wheel_cmd_q[$];
    int unsigned bad_count;

    function automatic logic [DRIVE_BITS-1:0] clamp_mag(input longint mag);
        return (mag > DRIVE_MAX) ? DRIVE_BITS'(DRIVE_MAX) : DRIVE_BITS'(mag);
    endfunction

    // one control step: threshold, error, pid, wheel split
    function automatic wheel_cmd_t steer_step(input logic [SAMPLE_BITS-1:0] l,
                                              input logic [SAMPLE_BITS-1:0] m,
                                              input logic [SAMPLE_BITS-1:0] r);
        logic [CODE_BITS-1:0] code;
        longint               err;
        longint               dt;
        longint               num;
        longint               pid;
        longint               lw;
        longint               rw;
        wheel_cmd_t           cmd;
        code = {l < thr_left, m < thr_mid, r < thr_right};
        dt   = (period == '0) ? 1 : longint'(period);
        case (code)
            CODE_CENTER:
            begin
                err     = ERR_NONE;
                err_sum = 0;
            end
            CODE_LEFT, CODE_LEFT_MID:   err = ERR_LEFT;
            CODE_RIGHT, CODE_RIGHT_MID: err = ERR_RIGHT;
            CODE_LOST:
            begin
                if (last_seen == CODE_LEFT || last_seen == CODE_LEFT_MID)
                    err = ERR_LEFT_LOST;
                else if (last_seen == CODE_RIGHT || last_seen == CODE_RIGHT_MID)
                    err = ERR_RIGHT_LOST;
                else
                    err = ERR_NONE;
            end
            default: err = ERR_NONE;
        endcase
        last_seen = code;

        err_sum = err_sum + err * dt;
        if (err_sum > SUM_HI)
            err_sum = SUM_HI;
        else if (err_sum < SUM_LO)
            err_sum = SUM_LO;

        num = dt * (longint'(kp) * err + longint'(ki) * err_sum)
            + longint'(kd) * (err - prior_err);
        pid = num / dt;
        prior_err = err;

        lw = longint'(base) + pid;
        rw = longint'(base) - pid;
        cmd.dir = '0;
        if (lw < 0)
        begin
            cmd.dir |= DIR_LEFT_BACK;
            lw = -lw;
        end
        if (rw < 0)
        begin
            cmd.dir |= DIR_RIGHT_BACK;
            rw = -rw;
        end
        cmd.left_mag  = clamp_mag(lw);
        cmd.right_mag = clamp_mag(rw);
        cmd.black     = code;
        return cmd;
    endfunction

    task automatic flag_beat(input string what, input wheel_cmd_t want, input wheel_cmd_t got);
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
            $display("%0t %s: expected dir=%0d left=%0d right=%0d black=%b, got dir=%0d left=%0d right=%0d black=%b",
                     $realtime, what, want.dir, want.left_mag, want.right_mag, want.black,
                     got.dir, got.left_mag, got.right_mag, got.black);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_beats
        wheel_cmd_t got;
        wheel_cmd_t want;
        if (!rst_n)
        begin
            kp        = RST_GAIN_PROP;
            ki        = RST_GAIN_INTEG;
            kd        = RST_GAIN_DERIV;
            period    = RST_STEP_TIME;
            base      = RST_BASE_SPEED;
            thr_left  = RST_LEFT_THR;
            thr_mid   = RST_MID_THR;
            thr_right = RST_RIGHT_THR;
            last_seen = CODE_CENTER;
            prior_err = 0;
            err_sum   = 0;
            bad_count = 0;
            wheel_cmd_q.delete();
            mismatches <= 0;
            owed       <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_GAIN_PROP:  kp        = cfg_data[GAIN_BITS-1:0];
                    CFG_GAIN_INTEG: ki        = cfg_data[GAIN_BITS-1:0];
                    CFG_GAIN_DERIV: kd        = cfg_data[GAIN_BITS-1:0];
                    CFG_STEP_TIME:  period    = cfg_data[GAIN_BITS-1:0];
                    CFG_BASE_SPEED: base      = cfg_data[BASE_BITS-1:0];
                    CFG_LEFT_THR:   thr_left  = cfg_data[SAMPLE_BITS-1:0];
                    CFG_MID_THR:    thr_mid   = cfg_data[SAMPLE_BITS-1:0];
                    CFG_RIGHT_THR:  thr_right = cfg_data[SAMPLE_BITS-1:0];
                    default: ;
                endcase
            end
            if (sense.valid && sense.ready)
                wheel_cmd_q.push_back(steer_step(sense.left_sample, sense.mid_sample,
                                                 sense.right_sample));
            if (drive.valid && drive.ready)
            begin
                got.dir       = drive.wheel_direction;
                got.left_mag  = drive.left_drive;
                got.right_mag = drive.right_drive;
                got.black     = drive.black_bits;
                if (wheel_cmd_q.size() == 0)
                    flag_beat("drive beat with nothing expected", '0, got);
                else
                begin
                    want = wheel_cmd_q.pop_front();
                    if (got.dir !== want.dir || got.left_mag !== want.left_mag ||
                        got.right_mag !== want.right_mag || got.black !== want.black)
                        flag_beat("drive beat mismatch", want, got);
                end
            end
            mismatches <= bad_count;
            owed       <= wheel_cmd_q.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
// testbench top for the line follower pid drive: clock, reset, register setup, sensor stimulus and
// drive back-pressure; depends on lfpd_pkg, lfpd_ifs, line_follow_pid_drive and lfpd_drive_checker
module tb;
    import lfpd_pkg::*;

    localparam int MAX_SAMPLE    = (1 << SAMPLE_BITS) - 1;
    localparam int CFG_MAX       = (1 << CFG_DATA_BITS) - 1;
    localparam logic [CFG_DATA_BITS-1:0] CFG_ALL_ONES = '1;
    localparam int MAX_GAP       = 18;
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int STALL_LIMIT   = 3000;    // cycles with no beat on either channel
    localparam int TAIL_CYCLES   = 60;      // room for any stray drive beat after the drain
    localparam int SAT_PAIRS     = 60;      // side/lost pairs that build up a large error sum
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 200;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int unsigned mismatch_total;
    int unsigned beats_owed;

    // stimulus side copies of the thresholds, only used to aim samples
    logic [SAMPLE_BITS-1:0] thr_l;
    logic [SAMPLE_BITS-1:0] thr_m;
    logic [SAMPLE_BITS-1:0] thr_r;

    bit          rush;          // back to back beats, no idling on either side
    bit          tx_calm;
    bit          rx_calm;
    int unsigned sent;
    int unsigned rx_beats;

    lfpd_sense_if sense_ch ();
    lfpd_drive_if drive_ch ();

    line_follow_pid_drive dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sense     (sense_ch),
        .drive     (drive_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lfpd_drive_checker drive_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .sense      (sense_ch),
        .drive      (drive_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatch_total),
        .owed       (beats_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // idle cycles before the next beat; zero in calm stretches and rush runs
    function automatic int unsigned draw_gap(input bit calm);
        return (calm || rush) ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // a sample on the requested side of its threshold, sometimes right at the boundary
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic black,
                                                           input logic [SAMPLE_BITS-1:0] thr);
        logic near_thr;
        near_thr = ($urandom_range(0, 7) == 0);
        if (black && thr != '0)
            return near_thr ? thr - 1'b1 : SAMPLE_BITS'($urandom_range(0, thr - 1));
        return near_thr ? thr : SAMPLE_BITS'($urandom_range(thr, MAX_SAMPLE));
    endfunction

    // gains: half small, half over the full port width (upper bits dropped by the block)
    function automatic logic [CFG_DATA_BITS-1:0] draw_gain();
        return ($urandom_range(0, 1) == 1) ? CFG_DATA_BITS'($urandom_range(0, 15))
                                           : CFG_DATA_BITS'($urandom_range(0, CFG_MAX));
    endfunction

    // one sensor beat; valid stays up when the next beat follows with no gap
    task automatic send_readings(input logic [SAMPLE_BITS-1:0] l,
                                 input logic [SAMPLE_BITS-1:0] m,
                                 input logic [SAMPLE_BITS-1:0] r);
        int unsigned gap;
        if (sent % 40 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        sent++;
        gap = draw_gap(tx_calm);
        if (gap != 0)
        begin
            sense_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sense_ch.valid        <= 1'b1;
        sense_ch.left_sample  <= l;
        sense_ch.mid_sample   <= m;
        sense_ch.right_sample <= r;
        do @(posedge clk); while (!sense_ch.ready);
    endtask

    // sensor beat that produces the given black code under the current thresholds
    task automatic send_code(input logic [CODE_BITS-1:0] code);
        send_readings(pick_sample(code[2], thr_l), pick_sample(code[1], thr_m),
                      pick_sample(code[0], thr_r));
    endtask

    // mostly line-shaped traffic: frequent line loss and re-centering, some raw noise
    task automatic send_random_item();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            send_readings(SAMPLE_BITS'($urandom_range(0, MAX_SAMPLE)),
                          SAMPLE_BITS'($urandom_range(0, MAX_SAMPLE)),
                          SAMPLE_BITS'($urandom_range(0, MAX_SAMPLE)));
        else if (pick < 5)
            send_code(CODE_LOST);
        else if (pick < 8)
            send_code(CODE_CENTER);
        else
            send_code(CODE_BITS'($urandom_range(0, 7)));
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // drain all outstanding drive beats, then rewrite every register
    task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] kp,
                                 input logic [CFG_DATA_BITS-1:0] ki,
                                 input logic [CFG_DATA_BITS-1:0] kd,
                                 input logic [CFG_DATA_BITS-1:0] dt,
                                 input logic [CFG_DATA_BITS-1:0] base,
                                 input logic [CFG_DATA_BITS-1:0] lt,
                                 input logic [CFG_DATA_BITS-1:0] mt,
                                 input logic [CFG_DATA_BITS-1:0] rt);
        sense_ch.valid <= 1'b0;
        do @(posedge clk); while (beats_owed != 0);
        write_reg(CFG_GAIN_PROP, kp);
        write_reg(CFG_GAIN_INTEG, ki);
        write_reg(CFG_GAIN_DERIV, kd);
        write_reg(CFG_STEP_TIME, dt);
        write_reg(CFG_BASE_SPEED, base);
        write_reg(CFG_LEFT_THR, lt);
        write_reg(CFG_MID_THR, mt);
        write_reg(CFG_RIGHT_THR, rt);
        cfg_we <= 1'b0;
        thr_l = lt[SAMPLE_BITS-1:0];
        thr_m = mt[SAMPLE_BITS-1:0];
        thr_r = rt[SAMPLE_BITS-1:0];
    endtask

    // receiver: random stalls per beat, calm stretches, and two long hold-offs
    // that let the block fill up and push back on the sensor channel
    initial
    begin : drive_sink
        int unsigned stall;
        drive_ch.ready <= 1'b0;
        rx_beats = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (rx_beats % 40 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (!rush && (rx_beats == 300 || rx_beats == 1200))
                stall = HOLD_CYCLES;
            else
                stall = draw_gap(rx_calm);
            if (stall != 0)
            begin
                drive_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            drive_ch.ready <= 1'b1;
            do @(posedge clk); while (!drive_ch.valid);
            if (!rush)
                rx_beats++;
        end
    end

    // watchdog: ends the run when neither channel moves a beat for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sense_ch.valid && sense_ch.ready) || (drive_ch.valid && drive_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        // known values on every input from time zero, reset held low
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_GAIN_PROP;
        cfg_data              <= '0;
        sense_ch.valid        <= 1'b0;
        sense_ch.left_sample  <= '0;
        sense_ch.mid_sample   <= '0;
        sense_ch.right_sample <= '0;
        rush    = 1'b0;
        tx_calm = 1'b0;
        sent    = 0;
        thr_l   = RST_LEFT_THR;
        thr_m   = RST_MID_THR;
        thr_r   = RST_RIGHT_THR;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains and thresholds: walk every code, line loss after each side,
        // lost twice in a row, and samples exactly at and one below each threshold
        send_readings(10'd1023, 10'd0, 10'd1023);      // centered
        send_readings(10'd0, 10'd1023, 10'd1023);      // left only
        send_readings(10'd1023, 10'd1023, 10'd1023);   // lost, last seen left
        send_readings(10'd1023, 10'd1023, 10'd1023);   // lost again, no side memory
        send_readings(10'd1023, 10'd1023, 10'd0);      // right only
        send_readings(10'd1023, 10'd1023, 10'd1023);   // lost, last seen right
        send_readings(10'd0, 10'd0, 10'd1023);         // left and middle
        send_readings(10'd1023, 10'd1023, 10'd1023);
        send_readings(10'd1023, 10'd0, 10'd0);         // middle and right
        send_readings(10'd1023, 10'd1023, 10'd1023);
        send_readings(10'd0, 10'd1023, 10'd0);         // both outer sensors
        send_readings(10'd0, 10'd0, 10'd0);            // all black
        send_readings(10'd1023, 10'd1023, 10'd1023);   // lost after all black
        send_readings(RST_LEFT_THR, RST_MID_THR, RST_RIGHT_THR);
        send_readings(RST_LEFT_THR - 1'b1, RST_MID_THR - 1'b1, RST_RIGHT_THR - 1'b1);
        send_readings(RST_LEFT_THR - 1'b1, RST_MID_THR, RST_RIGHT_THR);
        send_readings(RST_LEFT_THR, RST_MID_THR - 1'b1, RST_RIGHT_THR);
        send_readings(RST_LEFT_THR, RST_MID_THR, RST_RIGHT_THR - 1'b1);

        // all registers at the top, gains written with bits above their width
        apply_setting(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES,
                      CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
        send_readings(10'd1022, 10'd1023, 10'd1022);
        send_readings(10'd1023, 10'd1022, 10'd1023);

        // build up a large positive error sum
        rush = 1'b1;
        repeat (SAT_PAIRS)
        begin
            send_code(CODE_RIGHT);
            send_code(CODE_LOST);
        end
        send_code(CODE_RIGHT_MID);
        send_code(CODE_LOST);

        // unit integral gain, zero base: a large negative sum shows up as a reversed left
        // wheel, both wheels clamped
        apply_setting(10'd0, 10'd1, 10'd0, 10'd255, 10'd0, 10'd512, 10'd512, 10'd512);
        send_code(CODE_CENTER);
        repeat (SAT_PAIRS)
        begin
            send_code(CODE_LEFT);
            send_code(CODE_LOST);
        end
        send_code(CODE_LEFT_MID);
        send_code(CODE_LOST);
        rush = 1'b0;

        // everything at zero: period of zero acts as one, nothing reads black
        apply_setting('0, '0, '0, '0, '0, '0, '0, '0);
        repeat (4) send_random_item();

        // zero period with live gains
        apply_setting(10'd7, 10'd3, 10'd200, 10'd0, 10'd512, 10'd600, 10'd600, 10'd600);
        repeat (20) send_random_item();

        // random settings, each followed by a run of line-shaped traffic
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_setting(draw_gain(), draw_gain(), draw_gain(),
                          ($urandom_range(0, 4) == 0) ? '0
                                                      : CFG_DATA_BITS'($urandom_range(1, 255)),
                          CFG_DATA_BITS'($urandom_range(0, CFG_MAX)),
                          CFG_DATA_BITS'($urandom_range(1, CFG_MAX)),
                          CFG_DATA_BITS'($urandom_range(1, CFG_MAX)),
                          CFG_DATA_BITS'($urandom_range(1, CFG_MAX)));
            repeat (PHASE_ITEMS) send_random_item();
        end

        // drain, then leave room for any stray drive beat before the verdict
        sense_ch.valid <= 1'b0;
        do @(posedge clk); while (beats_owed != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && beats_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
